>>> hdl/espm_pkg.sv
// Shared types and constants of the encoder period speed meter.
package espm_pkg;

  // Field widths.
  localparam int OP_W       = 2;
  localparam int TS_W       = 16;
  localparam int PERIOD_W   = TS_W + 1;
  localparam int SPEED_W    = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 1;

  // Default channel count and reset values of the configuration registers.
  localparam int             CHANNELS_DEF     = 2;
  localparam logic [CFG_W-1:0] SCALE_RESET    = CFG_W'(200 * 250);
  localparam logic [CFG_W-1:0] DEAD_ZONE_RESET = '0;
  localparam logic [SPEED_W-1:0] SPEED_SAT    = 16'hFFFF;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Operation codes of an input word.
  typedef enum logic [OP_W-1:0] {
    OP_ARM  = 2'd0,
    OP_EDGE = 2'd1,
    OP_EVAL = 2'd2
  } op_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE     = 1'b0,
    CFG_DEAD_ZONE = 1'b1
  } cfg_idx_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_MEASURED  = 2'd0,
    ST_ONE_EDGE  = 2'd1,
    ST_NO_EDGE   = 2'd2,
    ST_DEAD_ZONE = 2'd3
  } status_e;

  // Measurement stage of one channel.
  typedef enum logic [1:0] {
    STG_IDLE  = 2'd0,
    STG_FIRST = 2'd1,
    STG_DONE  = 2'd2
  } stage_e;

  // Back end sequencer states.
  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_DIV  = 1'b1
  } back_state_e;

  // One evaluation job handed from front to back.
  typedef struct packed {
    logic                channel;
    status_e             kind;
    logic [PERIOD_W-1:0] period;
  } job_t;

endpackage

>>> hdl/espm_front.sv
// Front end: accepts input words, tracks capture state per channel, queues evaluations.
module espm_front #(
  parameter int CHANNELS = espm_pkg::CHANNELS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [espm_pkg::OP_W-1:0]  op_i,
  input  logic                       channel_i,
  input  logic [espm_pkg::TS_W-1:0]  timestamp_i,
  input  logic                       overflow_seen_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output espm_pkg::job_t             q_job_o
);
  import espm_pkg::*;

  stage_e              stage_q  [CHANNELS];
  logic [TS_W-1:0]     first_q  [CHANNELS];
  logic [PERIOD_W-1:0] period_q [CHANNELS];
  logic [CHANNELS-1:0] armed_q;

  logic [CHANNELS-1:0] sel;
  logic                ch_valid;
  logic                accept;
  stage_e              cur_stage;
  logic [TS_W-1:0]     cur_first;
  logic [PERIOD_W-1:0] cur_period;
  logic [PERIOD_W-1:0] new_period;
  logic                is_edge;
  logic                is_eval;

  // The queue only fills on evaluations, but every word waits for room to keep order simple.
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Decode the channel and pick that channel's state.
  always_comb begin
    cur_stage  = STG_IDLE;
    cur_first  = '0;
    cur_period = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      sel[i] = (int'(channel_i) == i);
      if (sel[i]) begin
        cur_stage  = stage_q[i];
        cur_first  = first_q[i];
        cur_period = period_q[i];
      end
    end
    ch_valid = (int'(channel_i) < CHANNELS);
  end

  // Period is the timestamp difference, with the overflow flag as bit sixteen.
  assign new_period = {overflow_seen_i, timestamp_i - cur_first};

  assign is_edge = accept && (op_i == OP_EDGE) && ch_valid && (|(armed_q & sel));
  assign is_eval = accept && (op_i == OP_EVAL);

  // Evaluation job for the back end.
  always_comb begin
    q_push_o        = is_eval;
    q_job_o.channel = channel_i;
    q_job_o.period  = cur_period;
    q_job_o.kind    = ST_NO_EDGE;
    if (ch_valid) begin
      case (cur_stage)
        STG_DONE:  q_job_o.kind = ST_MEASURED;
        STG_FIRST: q_job_o.kind = ST_ONE_EDGE;
        default:   q_job_o.kind = ST_NO_EDGE;
      endcase
    end
  end

  // Per-channel capture state and the armed mask.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        stage_q[i]  <= STG_IDLE;
        first_q[i]  <= '0;
        period_q[i] <= '0;
      end
    end else if (accept) begin
      case (op_i)
        OP_ARM: begin
          if (ch_valid) begin
            armed_q <= sel;
          end
        end
        OP_EDGE: begin
          if (is_edge) begin
            for (int i = 0; i < CHANNELS; i++) begin
              if (sel[i]) begin
                if (cur_stage == STG_FIRST) begin
                  period_q[i] <= new_period;
                  stage_q[i]  <= STG_DONE;
                end else begin
                  first_q[i] <= timestamp_i;
                  stage_q[i] <= STG_FIRST;
                end
              end
            end
            if (cur_stage == STG_FIRST) begin
              armed_q <= '0;
            end
          end
        end
        OP_EVAL: begin
          armed_q <= '0;
          for (int i = 0; i < CHANNELS; i++) begin
            if (sel[i]) begin
              stage_q[i]  <= STG_IDLE;
              first_q[i]  <= '0;
              period_q[i] <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> hdl/espm_fifo.sv
// Short job queue between the front and back ends.
module espm_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  espm_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output espm_pkg::job_t job_o
);
  import espm_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);

  job_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (count_q == (PtrW + 1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

>>> hdl/espm_back.sv
// Back end: serial divider for scale over period, dead zone check and result register.
module espm_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [espm_pkg::CFG_W-1:0]   scale_i,
  input  logic [espm_pkg::CFG_W-1:0]   dead_zone_i,
  input  logic                         job_valid_i,
  input  espm_pkg::job_t               job_i,
  output logic                         job_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [espm_pkg::SPEED_W-1:0] speed_o,
  output logic [1:0]                   status_o,
  output logic                         result_channel_o
);
  import espm_pkg::*;

  localparam int DivSteps = SPEED_W;
  localparam int CntW     = $clog2(DivSteps + 1);

  back_state_e         state_q, state_d;
  logic [PERIOD_W-1:0] rem_q, rem_d;
  logic [SPEED_W-1:0]  quo_q, quo_d;
  logic [PERIOD_W-1:0] div_q, div_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                chan_q, chan_d;

  logic                out_valid_q, out_valid_d;
  logic [SPEED_W-1:0]  speed_q, speed_d;
  status_e             status_q, status_d;
  logic                rchan_q, rchan_d;

  logic                slot_free;
  logic                needs_div;
  logic [PERIOD_W:0]   partial;
  logic [PERIOD_W:0]   diff;
  logic                ge;

  // A measured speed below the dead zone is reported as zero.
  function automatic void apply_dead_zone(input logic [SPEED_W-1:0] s,
                                          input logic [CFG_W-1:0] dz,
                                          output logic [SPEED_W-1:0] s_out,
                                          output status_e st_out);
    if (s < dz) begin
      s_out  = '0;
      st_out = ST_DEAD_ZONE;
    end else begin
      s_out  = s;
      st_out = ST_MEASURED;
    end
  endfunction

  assign slot_free = !out_valid_q || out_ready_i;
  assign needs_div = (job_i.kind == ST_MEASURED) && (job_i.period != '0);

  // One restoring division step.
  assign partial = {rem_q, quo_q[SPEED_W-1]};
  assign diff    = partial - {1'b0, div_q};
  assign ge      = (partial >= {1'b0, div_q});

  // Sequencer and datapath next state.
  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    div_d       = div_q;
    cnt_d       = cnt_q;
    chan_d      = chan_q;
    out_valid_d = out_valid_q;
    speed_d     = speed_q;
    status_d    = status_q;
    rchan_d     = rchan_q;
    job_pop_o   = 1'b0;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          if (needs_div) begin
            job_pop_o = 1'b1;
            rem_d     = '0;
            quo_d     = scale_i;
            div_d     = job_i.period;
            cnt_d     = '0;
            chan_d    = job_i.channel;
            state_d   = BK_DIV;
          end else if (slot_free) begin
            job_pop_o   = 1'b1;
            out_valid_d = 1'b1;
            rchan_d     = job_i.channel;
            if (job_i.kind == ST_MEASURED) begin
              // Zero period saturates the speed.
              apply_dead_zone(SPEED_SAT, dead_zone_i, speed_d, status_d);
            end else begin
              speed_d  = '0;
              status_d = job_i.kind;
            end
          end
        end
      end
      BK_DIV: begin
        if (cnt_q != CntW'(DivSteps)) begin
          rem_d = ge ? diff[PERIOD_W-1:0] : partial[PERIOD_W-1:0];
          quo_d = {quo_q[SPEED_W-2:0], ge};
          cnt_d = cnt_q + 1'b1;
        end else if (slot_free) begin
          out_valid_d = 1'b1;
          rchan_d     = chan_q;
          apply_dead_zone(quo_q, dead_zone_i, speed_d, status_d);
          state_d     = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    div_q    <= div_d;
    chan_q   <= chan_d;
    speed_q  <= speed_d;
    status_q <= status_d;
    rchan_q  <= rchan_d;
  end

  assign out_valid_o      = out_valid_q;
  assign speed_o          = speed_q;
  assign status_o         = status_q;
  assign result_channel_o = rchan_q;

endmodule

>>> hdl/encoder_period_speed_meter.sv
// Encoder period speed meter top level: configuration registers, front, queue and back.
//
// Arm and capture-edge words are accepted back to back while the two-entry evaluation
// queue has room. An evaluate word is pushed into the queue when it is accepted.
// Its result passes from the queue through the divider load, 16 steps of the shared
// restoring divider and the output register when a measured period is divided, and from
// the queue straight into the output register when no division is needed (no edge, one
// edge only, or zero period). The serial divider takes a new evaluation only once it has
// finished the last one. The output register lets the next job start its division while
// a result waits to be taken; a job that needs no division waits until it is taken.
module encoder_period_speed_meter #(
  parameter int CHANNELS = espm_pkg::CHANNELS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [espm_pkg::OP_W-1:0]      op_i,
  input  logic                           channel_i,
  input  logic [espm_pkg::TS_W-1:0]      timestamp_i,
  input  logic                           overflow_seen_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [espm_pkg::SPEED_W-1:0]   speed_o,
  output logic [1:0]                     status_o,
  output logic                           result_channel_o,
  input  logic                           cfg_we_i,
  input  logic [espm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [espm_pkg::CFG_W-1:0]     cfg_data_i
);
  import espm_pkg::*;

  logic [CFG_W-1:0] scale_q;
  logic [CFG_W-1:0] dead_zone_q;
  logic             q_full;
  logic             q_push;
  job_t             q_job_in;
  logic             q_pop;
  logic             q_valid;
  job_t             q_job_out;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q     <= SCALE_RESET;
      dead_zone_q <= DEAD_ZONE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SCALE:     scale_q     <= cfg_data_i;
        CFG_DEAD_ZONE: dead_zone_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  espm_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .channel_i      (channel_i),
    .timestamp_i    (timestamp_i),
    .overflow_seen_i(overflow_seen_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_job_o        (q_job_in)
  );

  espm_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .job_i  (q_job_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .job_o  (q_job_out)
  );

  espm_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .scale_i         (scale_q),
    .dead_zone_i     (dead_zone_q),
    .job_valid_i     (q_valid),
    .job_i           (q_job_out),
    .job_pop_o       (q_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .speed_o         (speed_o),
    .status_o        (status_o),
    .result_channel_o(result_channel_o)
  );

endmodule
